[rtl/core/kbd_diff_pkg.sv]
// ----------------------------------------------------------------------------
// kbd_diff_pkg
// Shared types and constants of the keyboard report key differ.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kbd_diff_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int MAX_SLOTS = 6;
	localparam int SLOTS     = (KEY_SLOTS < 1) ? 1 :
	                           ((KEY_SLOTS > MAX_SLOTS) ? MAX_SLOTS : KEY_SLOTS);
	localparam int KEY_W     = 8;
	localparam int LIST_W    = MAX_SLOTS * KEY_W;
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int IDX_W     = $clog2(MAX_SLOTS);

	localparam logic [KEY_W-1:0] ROLLOVER_CODE = 8'h01;
	localparam logic [KEY_W-1:0] EMPTY_CODE    = 8'h00;

	typedef logic [KEY_W-1:0] key_t;
	typedef key_t [SLOTS-1:0] key_set_t;

	typedef struct packed {
		logic pressed;
		logic released;
	} lane_flags_t;

	typedef lane_flags_t [SLOTS-1:0] lane_flags_set_t;

	typedef struct packed {
		logic [LIST_W-1:0] pressed_list;
		logic [CNT_W-1:0]  pressed_count;
		logic [LIST_W-1:0] released_list;
		logic [CNT_W-1:0]  released_count;
		logic              rollover_seen;
	} result_t;

endpackage

`default_nettype wire

[rtl/core/kbd_diff_if.sv]
// ----------------------------------------------------------------------------
// kbd_diff_if
// Valid/ready channels for report items and diff result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kbd_diff_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_slot_0;
	logic [7:0] key_slot_1;
	logic [7:0] key_slot_2;
	logic [7:0] key_slot_3;
	logic [7:0] key_slot_4;
	logic [7:0] key_slot_5;

	modport source (
		output valid, key_slot_0, key_slot_1, key_slot_2,
		       key_slot_3, key_slot_4, key_slot_5,
		input  ready
	);
	modport sink (
		input  valid, key_slot_0, key_slot_1, key_slot_2,
		       key_slot_3, key_slot_4, key_slot_5,
		output ready
	);
endinterface

interface kbd_diff_out_if;
	logic        valid;
	logic        ready;
	logic [47:0] pressed_list;
	logic [2:0]  pressed_count;
	logic [47:0] released_list;
	logic [2:0]  released_count;
	logic        rollover_seen;

	modport source (
		output valid, pressed_list, pressed_count, released_list,
		       released_count, rollover_seen,
		input  ready
	);
	modport sink (
		input  valid, pressed_list, pressed_count, released_list,
		       released_count, rollover_seen,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/kbd_diff_lane.sv]
// ----------------------------------------------------------------------------
// kbd_diff_lane
// One slot lane: tests its new code against the old report and its old code
// against the new report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kbd_diff_lane
	import kbd_diff_pkg::*;
(
	input  key_t        cur_code,
	input  key_t        prev_code,
	input  key_set_t    cur_keys,
	input  key_set_t    prev_keys,
	output lane_flags_t flags
);

	logic in_prev;
	logic in_cur;

	always_comb begin
		in_prev = 1'b0;
		in_cur  = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if (prev_keys[j] == cur_code) begin
				in_prev = 1'b1;
			end
			if (cur_keys[j] == prev_code) begin
				in_cur = 1'b1;
			end
		end
		flags.pressed  = (cur_code != EMPTY_CODE) && !in_prev;
		flags.released = (prev_code != EMPTY_CODE) && !in_cur;
	end

endmodule

`default_nettype wire

[rtl/core/kbd_diff_merge.sv]
// ----------------------------------------------------------------------------
// kbd_diff_merge
// Packs the flagged codes of all lanes in slot order and counts them, or gives empty lists on rollover.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kbd_diff_merge
	import kbd_diff_pkg::*;
(
	input  lane_flags_set_t flags,
	input  key_set_t        cur_keys,
	input  key_set_t        prev_keys,
	input  logic            rollover,
	output result_t         result
);

	key_t [MAX_SLOTS-1:0] p_bytes;
	key_t [MAX_SLOTS-1:0] r_bytes;
	logic [CNT_W-1:0]     p_pos;
	logic [CNT_W-1:0]     r_pos;

	always_comb begin
		p_bytes = '0;
		r_bytes = '0;
		p_pos   = '0;
		r_pos   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (flags[i].pressed) begin
				p_bytes[p_pos[IDX_W-1:0]] = cur_keys[i];
				p_pos = p_pos + CNT_W'(1);
			end
			if (flags[i].released) begin
				r_bytes[r_pos[IDX_W-1:0]] = prev_keys[i];
				r_pos = r_pos + CNT_W'(1);
			end
		end
		if (rollover) begin
			result.pressed_list   = '0;
			result.pressed_count  = '0;
			result.released_list  = '0;
			result.released_count = '0;
			result.rollover_seen  = 1'b1;
		end else begin
			result.pressed_list   = p_bytes;
			result.pressed_count  = p_pos;
			result.released_list  = r_bytes;
			result.released_count = r_pos;
			result.rollover_seen  = 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/core/keyboard_report_key_diff.sv]
// ----------------------------------------------------------------------------
// keyboard_report_key_diff
// Press/release differ for boot keyboard reports, one lane per key slot.
//
//   channel  | dir | contents
//   ---------+-----+----------------------------------------------------------
//   report   | in  | key_slot_0 .. key_slot_5
//   result   | out | pressed_list/count, released_list/count, rollover_seen
//
// one item per cycle while report.ready is high; each result is registered
// the lane compare matrix and packing settle in the cycle of acceptance
// arst_n clears the stored report to all empty slots and drops both valids
// an output register plus a skid register keep report.ready high through one
// stalled result; ready falls only once both hold an item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keyboard_report_key_diff
	import kbd_diff_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	kbd_diff_in_if.sink   report,
	kbd_diff_out_if.source result
);

	key_t [MAX_SLOTS-1:0] slot_codes;
	key_set_t             cur_keys;
	key_set_t             prev_keys_q;
	lane_flags_set_t      lane_flags;
	logic                 rollover;
	logic                 accept;
	result_t              diff;
	result_t              out_q;
	result_t              skid_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;

	assign slot_codes = {report.key_slot_5, report.key_slot_4, report.key_slot_3,
	                     report.key_slot_2, report.key_slot_1, report.key_slot_0};

	always_comb begin
		rollover = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			cur_keys[i] = slot_codes[i];
			if (slot_codes[i] != ROLLOVER_CODE) begin
				rollover = 1'b0;
			end
		end
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_lane
		kbd_diff_lane u_lane (
			.cur_code  (cur_keys[g]),
			.prev_code (prev_keys_q[g]),
			.cur_keys  (cur_keys),
			.prev_keys (prev_keys_q),
			.flags     (lane_flags[g])
		);
	end

	kbd_diff_merge u_merge (
		.flags     (lane_flags),
		.cur_keys  (cur_keys),
		.prev_keys (prev_keys_q),
		.rollover  (rollover),
		.result    (diff)
	);

	assign report.ready = !skid_valid_q;
	assign accept       = report.valid && report.ready;

	// stored report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q <= '0;
		end else if (accept && !rollover) begin
			prev_keys_q <= cur_keys;
		end
	end

	// output and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (out_valid_q && !result.ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (result.ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (out_valid_q && !result.ready) begin
				skid_q <= diff;
			end else begin
				out_q <= diff;
			end
		end else if (result.ready && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.pressed_list   = out_q.pressed_list;
	assign result.pressed_count  = out_q.pressed_count;
	assign result.released_list  = out_q.released_list;
	assign result.released_count = out_q.released_count;
	assign result.rollover_seen  = out_q.rollover_seen;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while output register is empty");

	a_rollover_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.rollover_seen) |->
		(out_q.pressed_count == '0 && out_q.released_count == '0))
		else $error("rollover result carries listed codes");

	a_rollover_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rollover) |=> $stable(prev_keys_q))
		else $error("rollover report changed the stored report");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.pressed_count <= CNT_W'(SLOTS) &&
		out_q.released_count <= CNT_W'(SLOTS)))
		else $error("count exceeds number of slots");

endmodule

`default_nettype wire

[sim/kbd_diff_checker.sv]
// ----------------------------------------------------------------------------
// kbd_diff_checker
// Watches the report and result channels of the key differ. Every accepted
// report item is run through a predictor that keeps its own copy of the
// stored report. The expected diff is queued, and each accepted result item
// is compared field by field with the oldest entry in the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbd_diff_checker
	import kbd_diff_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	kbd_diff_in_if   report,
	kbd_diff_out_if  result,
	output int       mismatches,
	output int       pending
);

	localparam int PRINT_CAP = 200;

	key_t    last_keys [MAX_SLOTS];
	result_t diff_q [$];
	result_t want;

	function automatic bit key_held(input key_t set [MAX_SLOTS], input key_t code);
		for (int j = 0; j < SLOTS; j++) begin
			if (set[j] == code) return 1'b1;
		end
		return 1'b0;
	endfunction

	// updates the stored report unless the item is a rollover
	function automatic result_t diff_report(input logic [LIST_W-1:0] word);
		key_t    keys [MAX_SLOTS];
		result_t res;
		bit      rollover;
		int      n_press;
		int      n_release;
		res       = '0;
		rollover  = 1'b1;
		n_press   = 0;
		n_release = 0;
		for (int i = 0; i < MAX_SLOTS; i++) keys[i] = word[KEY_W*i +: KEY_W];
		for (int i = 0; i < SLOTS; i++) begin
			if (keys[i] != ROLLOVER_CODE) rollover = 1'b0;
		end
		if (rollover) begin
			res.rollover_seen = 1'b1;
			return res;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (keys[i] != EMPTY_CODE && !key_held(last_keys, keys[i])) begin
				res.pressed_list[KEY_W*n_press +: KEY_W] = keys[i];
				n_press++;
			end
			if (last_keys[i] != EMPTY_CODE && !key_held(keys, last_keys[i])) begin
				res.released_list[KEY_W*n_release +: KEY_W] = last_keys[i];
				n_release++;
			end
		end
		res.pressed_count  = CNT_W'(n_press);
		res.released_count = CNT_W'(n_release);
		for (int i = 0; i < SLOTS; i++) last_keys[i] = keys[i];
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [LIST_W-1:0] got,
			input logic [LIST_W-1:0] exp_val);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("%0t ns: %s got %h, expected %h", $time, field, got, exp_val);
		end
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) last_keys[i] = EMPTY_CODE;
			diff_q.delete();
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (diff_q.size() == 0) begin
					report_mismatch("result item with no report waiting",
						result.pressed_list, '0);
				end else begin
					want = diff_q.pop_front();
					if (result.pressed_list !== want.pressed_list)
						report_mismatch("pressed_list", result.pressed_list,
							want.pressed_list);
					if (result.pressed_count !== want.pressed_count)
						report_mismatch("pressed_count", LIST_W'(result.pressed_count),
							LIST_W'(want.pressed_count));
					if (result.released_list !== want.released_list)
						report_mismatch("released_list", result.released_list,
							want.released_list);
					if (result.released_count !== want.released_count)
						report_mismatch("released_count", LIST_W'(result.released_count),
							LIST_W'(want.released_count));
					if (result.rollover_seen !== want.rollover_seen)
						report_mismatch("rollover_seen", LIST_W'(result.rollover_seen),
							LIST_W'(want.rollover_seen));
				end
			end
			if (report.valid && report.ready) begin
				diff_q.push_back(diff_report({report.key_slot_5, report.key_slot_4,
					report.key_slot_3, report.key_slot_2, report.key_slot_1,
					report.key_slot_0}));
			end
			pending <= diff_q.size();
		end
	end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives the key differ with a short directed run of report items and then
// random reports that mostly evolve from the last one, with rollover, near
// rollover, duplicate and fully random reports mixed in. The sender works in
// bursts and the receiver stalls on patterns of its own; the checker beside
// the block predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import kbd_diff_pkg::*;

	localparam int RANDOM_ITEMS = 1600;
	localparam int PAUSE_AT     = 800;
	localparam int HOLD_AT      = 1200;
	localparam int HOLD_LEN     = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int N_DIRECTED   = 18;

	localparam logic [LIST_W-1:0] ROLLOVER_REPORT = {MAX_SLOTS{ROLLOVER_CODE}};

	localparam logic [LIST_W-1:0] DIRECTED [N_DIRECTED] = '{
		48'h000000000000,
		48'h000000060504,
		48'h000000060504,
		48'h000000000004,
		48'h010101010101,
		48'h000000000000,
		48'h010101010101,
		48'h000101010101,
		48'h010101010100,
		48'hffffffffffff,
		48'h7f80fe01aa55,
		48'h55aa01fe807f,
		48'h0000000000ff,
		48'hff0000000000,
		48'h000000000000,
		48'h0101010101ff,
		48'h040404040404,
		48'h000000000000
	};

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   pending;

	logic [LIST_W-1:0] held;

	kbd_diff_in_if  report_ch ();
	kbd_diff_out_if result_ch ();

	keyboard_report_key_diff DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.report (report_ch),
		.result (result_ch)
	);

	kbd_diff_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.report     (report_ch),
		.result     (result_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	function automatic key_t pick_code();
		case ($urandom_range(0, 9))
			0: return EMPTY_CODE;
			1: return key_t'($urandom_range(0, 255));
			default: return key_t'($urandom_range(4, 11));
		endcase
	endfunction

	task automatic drive_slots(input logic [LIST_W-1:0] word);
		report_ch.key_slot_0 <= word[7:0];
		report_ch.key_slot_1 <= word[15:8];
		report_ch.key_slot_2 <= word[23:16];
		report_ch.key_slot_3 <= word[31:24];
		report_ch.key_slot_4 <= word[39:32];
		report_ch.key_slot_5 <= word[47:40];
	endtask

	task automatic send_report(input logic [LIST_W-1:0] word);
		report_ch.valid <= 1'b1;
		drive_slots(word);
		@(posedge clk);
		while (!report_ch.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending != 0);
	endtask

	// most reports grow out of the last non-rollover report so keys stay held
	task automatic build_report(output logic [LIST_W-1:0] word);
		int   mode;
		int   a;
		int   b;
		key_t code;
		mode = $urandom_range(0, 99);
		word = held;
		if (mode < 60) begin
			for (int k = 0; k < MAX_SLOTS; k++) begin
				case ($urandom_range(0, 7))
					0: word[KEY_W*k +: KEY_W] = EMPTY_CODE;
					1: word[KEY_W*k +: KEY_W] = pick_code();
					default: ;
				endcase
			end
			if ($urandom_range(0, 3) == 0) begin
				a = $urandom_range(0, MAX_SLOTS - 1);
				b = $urandom_range(0, MAX_SLOTS - 1);
				code = word[KEY_W*a +: KEY_W];
				word[KEY_W*a +: KEY_W] = word[KEY_W*b +: KEY_W];
				word[KEY_W*b +: KEY_W] = code;
			end
		end else if (mode < 68) begin
			word = ROLLOVER_REPORT;
		end else if (mode < 78) begin
			word = ROLLOVER_REPORT;
			a = $urandom_range(0, MAX_SLOTS - 1);
			word[KEY_W*a +: KEY_W] = key_t'($urandom_range(0, 255));
		end else if (mode < 90) begin
			word[31:0]  = $urandom;
			word[47:32] = 16'($urandom);
		end else begin
			code = pick_code();
			for (int k = 0; k < MAX_SLOTS; k++) begin
				word[KEY_W*k +: KEY_W] = ($urandom_range(0, 2) == 0) ? EMPTY_CODE : code;
			end
		end
		if (word != ROLLOVER_REPORT) held = word;
	endtask

	initial begin
		logic [LIST_W-1:0] word;
		int                burst_left;
		int                gap;
		arst_n          = 1'b0;
		report_ch.valid = 1'b0;
		drive_slots('0);
		held = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) send_report(DIRECTED[i]);

		burst_left = $urandom_range(1, 24);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PAUSE_AT) begin
				report_ch.valid <= 1'b0;
				wait_drained();
			end
			build_report(word);
			send_report(word);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap > 0) begin
					report_ch.valid <= 1'b0;
					drive_slots(LIST_W'({$urandom, $urandom} >> 16));
					repeat (gap) @(posedge clk);
				end
			end
		end
		report_ch.valid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// receiver stall patterns, plus one long hold-off so the block backs up
	initial begin
		int own_cycles;
		int mode;
		int phase_left;
		own_cycles = 0;
		mode       = 0;
		phase_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			own_cycles++;
			if (own_cycles == HOLD_AT) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				own_cycles += HOLD_LEN;
			end else begin
				if (phase_left == 0) begin
					mode       = $urandom_range(0, 3);
					phase_left = $urandom_range(10, 150);
				end
				phase_left--;
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					2: result_ch.ready <= ($urandom_range(0, 4) == 0);
					default: result_ch.ready <= ((own_cycles % 3) != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/kbd_diff_pkg.sv
rtl/core/kbd_diff_if.sv
rtl/core/kbd_diff_lane.sv
rtl/core/kbd_diff_merge.sv
rtl/core/keyboard_report_key_diff.sv
sim/kbd_diff_checker.sv
sim/tb_top.sv
